FILE: src/lcss_pkg.sv
// ----------------------------------------------------------------------------
// lcss_pkg
// shared types and constants for the line crossing segment splitter
// ----------------------------------------------------------------------------
`default_nettype none

package lcss_pkg;

    localparam int TOL_W = 31;
    localparam logic [TOL_W-1:0] TOL_RESET = 31'd7;

    localparam logic [1:0] END_FIRST_END    = 2'd0;
    localparam logic [1:0] END_FIRST_START  = 2'd1;
    localparam logic [1:0] END_SECOND_START = 2'd2;
    localparam logic [1:0] END_SECOND_END   = 2'd3;

    typedef struct packed {
        logic valid;
        logic par;
        logic neg_x;
        logic neg_y;
        logic ovf_x;
        logic ovf_y;
    } t_ctl;

endpackage

`default_nettype wire

FILE: src/lcss_if.sv
// ----------------------------------------------------------------------------
// lcss channels
// valid/ready channels for line words, result words and tolerance writes
// ----------------------------------------------------------------------------
`default_nettype none

interface lcss_in_if #(parameter int COORD_WIDTH = 32);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] first_start_x;
    logic signed [COORD_WIDTH-1:0] first_start_y;
    logic signed [COORD_WIDTH-1:0] first_end_x;
    logic signed [COORD_WIDTH-1:0] first_end_y;
    logic signed [COORD_WIDTH-1:0] second_start_x;
    logic signed [COORD_WIDTH-1:0] second_start_y;
    logic signed [COORD_WIDTH-1:0] second_end_x;
    logic signed [COORD_WIDTH-1:0] second_end_y;

    modport source (
        output valid, first_start_x, first_start_y, first_end_x, first_end_y,
               second_start_x, second_start_y, second_end_x, second_end_y,
        input  ready
    );
    modport sink (
        input  valid, first_start_x, first_start_y, first_end_x, first_end_y,
               second_start_x, second_start_y, second_end_x, second_end_y,
        output ready
    );
endinterface

interface lcss_out_if #(parameter int COORD_WIDTH = 32);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] cross_x;
    logic signed [COORD_WIDTH-1:0] cross_y;
    logic signed [COORD_WIDTH-1:0] far_x;
    logic signed [COORD_WIDTH-1:0] far_y;
    logic [1:0]                    which_end;
    logic                          segment_valid;
    logic                          parallel;
    logic                          saturated;
    logic                          last;

    modport source (
        output valid, cross_x, cross_y, far_x, far_y, which_end,
               segment_valid, parallel, saturated, last,
        input  ready
    );
    modport sink (
        input  valid, cross_x, cross_y, far_x, far_y, which_end,
               segment_valid, parallel, saturated, last,
        output ready
    );
endinterface

interface lcss_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [lcss_pkg::TOL_W-1:0]    tolerance;

    modport source (output valid, tolerance, input ready);
    modport sink (input valid, tolerance, output ready);
endinterface

`default_nettype wire

FILE: src/lcss_front.sv
// ----------------------------------------------------------------------------
// lcss_front
// line coefficients, determinant and cramer numerators, split products,
// magnitudes and divider setup
// ----------------------------------------------------------------------------
`default_nettype none

module lcss_front #(
    parameter int W = 32
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_adv,
    input  wire                           i_valid,
    input  wire  [8*W-1:0]                i_coord,
    output lcss_pkg::t_ctl                o_ctl,
    output logic [8*W-1:0]                o_coord,
    output logic [2*W+2:0]                o_md,
    output logic [2*W+2:0]                o_rem_x,
    output logic [2*W+2:0]                o_rem_y,
    output logic [W-1:0]                  o_low_x,
    output logic [W-1:0]                  o_low_y
);
    import lcss_pkg::*;

    localparam int AW = W + 1;
    localparam int CW = 2 * W + 2;
    localparam int DW = 2 * W + 3;
    localparam int HW = W + 1;
    localparam int PW = 2 * W + 3;
    localparam int NW = 3 * W + 4;

    logic r1_v, r2_v, r3_v, r4_v, r5_v, r6_v, r7_v;
    logic [8*W-1:0] r1_c, r2_c, r3_c, r4_c, r5_c, r6_c, r7_c, r8_c;

    logic signed [AW-1:0] r1_a1, r1_b1, r1_a2, r1_b2;
    logic signed [AW-1:0] r2_a1, r2_b1, r2_a2, r2_b2;
    logic signed [AW-1:0] r3_a1, r3_b1, r3_a2, r3_b2;
    logic signed [2*W:0]  r2_a1x, r2_b1y, r2_a2x, r2_b2y;
    logic signed [CW-1:0] r2_d1, r2_d2;
    logic signed [CW-1:0] r3_c1, r3_c2;
    logic signed [DW-1:0] r3_det, r4_det, r5_det, r6_det;
    logic signed [PW-1:0] r4_b2c1l, r4_b2c1h, r4_b1c2l, r4_b1c2h;
    logic signed [PW-1:0] r4_a1c2l, r4_a1c2h, r4_a2c1l, r4_a2c1h;
    logic signed [PW:0]   r5_hx, r5_lx, r5_hy, r5_ly;
    logic signed [NW-1:0] r6_nx, r6_ny;
    logic [NW-1:0]        r7_mx, r7_my;
    logic [DW-1:0]        r7_md, r8_md;
    t_ctl                 r7_ctl, r8_ctl;
    logic [DW-1:0]        r8_rem_x, r8_rem_y;
    logic [W-1:0]         r8_low_x, r8_low_y;

    logic signed [W-1:0]  c0, c1, c2, c3, c4, c5, c6, c7;
    logic signed [NW-1:0] n7_dsh;

    assign c0 = i_coord[0*W +: W];
    assign c1 = i_coord[1*W +: W];
    assign c2 = i_coord[2*W +: W];
    assign c3 = i_coord[3*W +: W];
    assign c4 = i_coord[4*W +: W];
    assign c5 = i_coord[5*W +: W];
    assign c6 = i_coord[6*W +: W];
    assign c7 = i_coord[7*W +: W];

    assign n7_dsh = NW'(r7_md) << W;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
            r6_v <= 1'b0;
            r7_v <= 1'b0;
            r8_ctl <= '0;
        end else if (i_adv) begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
            r5_v <= r4_v;
            r6_v <= r5_v;
            r7_v <= r6_v;
            r8_ctl <= '{valid: r7_v, par: r7_ctl.par, neg_x: r7_ctl.neg_x,
                        neg_y: r7_ctl.neg_y, ovf_x: r7_mx >= n7_dsh,
                        ovf_y: r7_my >= n7_dsh};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            // coefficients
            r1_c  <= i_coord;
            r1_a1 <= {c3[W-1], c3} - {c1[W-1], c1};
            r1_b1 <= {c0[W-1], c0} - {c2[W-1], c2};
            r1_a2 <= {c7[W-1], c7} - {c5[W-1], c5};
            r1_b2 <= {c4[W-1], c4} - {c6[W-1], c6};
            // first products
            r2_c   <= r1_c;
            r2_a1  <= r1_a1;
            r2_b1  <= r1_b1;
            r2_a2  <= r1_a2;
            r2_b2  <= r1_b2;
            r2_a1x <= r1_a1 * $signed(r1_c[0*W +: W]);
            r2_b1y <= r1_b1 * $signed(r1_c[1*W +: W]);
            r2_a2x <= r1_a2 * $signed(r1_c[4*W +: W]);
            r2_b2y <= r1_b2 * $signed(r1_c[5*W +: W]);
            r2_d1  <= r1_a1 * r1_b2;
            r2_d2  <= r1_a2 * r1_b1;
            // c terms and determinant
            r3_c   <= r2_c;
            r3_a1  <= r2_a1;
            r3_b1  <= r2_b1;
            r3_a2  <= r2_a2;
            r3_b2  <= r2_b2;
            r3_c1  <= CW'(r2_a1x) + CW'(r2_b1y);
            r3_c2  <= CW'(r2_a2x) + CW'(r2_b2y);
            r3_det <= DW'(r2_d1) - DW'(r2_d2);
            // split products, c taken as signed high half and unsigned low half
            r4_c     <= r3_c;
            r4_det   <= r3_det;
            r4_b2c1l <= r3_b2 * $signed({1'b0, r3_c1[HW-1:0]});
            r4_b2c1h <= r3_b2 * $signed(r3_c1[CW-1:HW]);
            r4_b1c2l <= r3_b1 * $signed({1'b0, r3_c2[HW-1:0]});
            r4_b1c2h <= r3_b1 * $signed(r3_c2[CW-1:HW]);
            r4_a1c2l <= r3_a1 * $signed({1'b0, r3_c2[HW-1:0]});
            r4_a1c2h <= r3_a1 * $signed(r3_c2[CW-1:HW]);
            r4_a2c1l <= r3_a2 * $signed({1'b0, r3_c1[HW-1:0]});
            r4_a2c1h <= r3_a2 * $signed(r3_c1[CW-1:HW]);
            // partial differences
            r5_c   <= r4_c;
            r5_det <= r4_det;
            r5_hx  <= (PW+1)'(r4_b2c1h) - (PW+1)'(r4_b1c2h);
            r5_lx  <= (PW+1)'(r4_b2c1l) - (PW+1)'(r4_b1c2l);
            r5_hy  <= (PW+1)'(r4_a1c2h) - (PW+1)'(r4_a2c1h);
            r5_ly  <= (PW+1)'(r4_a1c2l) - (PW+1)'(r4_a2c1l);
            // numerators
            r6_c   <= r5_c;
            r6_det <= r5_det;
            r6_nx  <= (NW'(r5_hx) <<< HW) + NW'(r5_lx);
            r6_ny  <= (NW'(r5_hy) <<< HW) + NW'(r5_ly);
            // magnitudes
            r7_c   <= r6_c;
            r7_mx  <= r6_nx[NW-1] ? NW'(-r6_nx) : NW'(r6_nx);
            r7_my  <= r6_ny[NW-1] ? NW'(-r6_ny) : NW'(r6_ny);
            r7_md  <= r6_det[DW-1] ? DW'(-r6_det) : DW'(r6_det);
            r7_ctl.valid <= 1'b0;
            r7_ctl.par   <= r6_det == '0;
            r7_ctl.neg_x <= r6_nx[NW-1] ^ r6_det[DW-1];
            r7_ctl.neg_y <= r6_ny[NW-1] ^ r6_det[DW-1];
            r7_ctl.ovf_x <= 1'b0;
            r7_ctl.ovf_y <= 1'b0;
            // divider setup
            r8_c     <= r7_c;
            r8_md    <= r7_md;
            r8_rem_x <= DW'(r7_mx >> W);
            r8_rem_y <= DW'(r7_my >> W);
            r8_low_x <= r7_mx[W-1:0];
            r8_low_y <= r7_my[W-1:0];
        end
    end

    assign o_ctl   = r8_ctl;
    assign o_coord = r8_c;
    assign o_md    = r8_md;
    assign o_rem_x = r8_rem_x;
    assign o_rem_y = r8_rem_y;
    assign o_low_x = r8_low_x;
    assign o_low_y = r8_low_y;

endmodule

`default_nettype wire

FILE: src/lcss_div_cell.sv
// ----------------------------------------------------------------------------
// lcss_div_cell
// one restoring divider step for x and y, quotient bit shifted into the
// low word as the numerator bit leaves it
// ----------------------------------------------------------------------------
`default_nettype none

module lcss_div_cell #(
    parameter int W = 32
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_adv,
    input  wire lcss_pkg::t_ctl   i_ctl,
    input  wire  [8*W-1:0]        i_coord,
    input  wire  [2*W+2:0]        i_md,
    input  wire  [2*W+2:0]        i_rem_x,
    input  wire  [2*W+2:0]        i_rem_y,
    input  wire  [W-1:0]          i_low_x,
    input  wire  [W-1:0]          i_low_y,
    output lcss_pkg::t_ctl        o_ctl,
    output logic [8*W-1:0]        o_coord,
    output logic [2*W+2:0]        o_md,
    output logic [2*W+2:0]        o_rem_x,
    output logic [2*W+2:0]        o_rem_y,
    output logic [W-1:0]          o_low_x,
    output logic [W-1:0]          o_low_y
);
    import lcss_pkg::*;

    localparam int DW = 2 * W + 3;

    t_ctl          r_ctl;
    logic [8*W-1:0] r_coord;
    logic [DW-1:0] r_md, r_rem_x, r_rem_y;
    logic [W-1:0]  r_low_x, r_low_y;

    logic [DW:0]   tx, ty, dd;
    logic          gex, gey;

    assign tx  = {i_rem_x, i_low_x[W-1]};
    assign ty  = {i_rem_y, i_low_y[W-1]};
    assign dd  = {1'b0, i_md};
    assign gex = tx >= dd;
    assign gey = ty >= dd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_adv) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_coord <= i_coord;
            r_md    <= i_md;
            r_rem_x <= gex ? DW'(tx - dd) : DW'(tx);
            r_rem_y <= gey ? DW'(ty - dd) : DW'(ty);
            r_low_x <= {i_low_x[W-2:0], gex};
            r_low_y <= {i_low_y[W-2:0], gey};
        end
    end

    assign o_ctl   = r_ctl;
    assign o_coord = r_coord;
    assign o_md    = r_md;
    assign o_rem_x = r_rem_x;
    assign o_rem_y = r_rem_y;
    assign o_low_x = r_low_x;
    assign o_low_y = r_low_y;

endmodule

`default_nettype wire

FILE: src/lcss_back.sv
// ----------------------------------------------------------------------------
// lcss_back
// quotient clamp, endpoint distance test, per-endpoint result split and
// output register; drives the pipeline advance
// ----------------------------------------------------------------------------
`default_nettype none

module lcss_back #(
    parameter int W = 32
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire lcss_pkg::t_ctl          i_ctl,
    input  wire  [8*W-1:0]               i_coord,
    input  wire  [W-1:0]                 i_q_x,
    input  wire  [W-1:0]                 i_q_y,
    input  wire  [lcss_pkg::TOL_W-1:0]   i_tol,
    output logic                         o_adv,
    lcss_out_if.source                   o_out
);
    import lcss_pkg::*;

    localparam int CMPW = (W + 1 > TOL_W) ? W + 1 : TOL_W;
    localparam logic signed [W-1:0] CMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] CMIN = {1'b1, {(W-1){1'b0}}};

    // clamp stage
    logic                r1_v, r1_sat, r1_par;
    logic signed [W-1:0] r1_px, r1_py;
    logic [8*W-1:0]      r1_c;
    logic signed [W-1:0] n1_px, n1_py;
    logic                n1_satx, n1_saty;

    // distance stage
    logic                r2_v, r2_sat, r2_par;
    logic signed [W-1:0] r2_px, r2_py;
    logic [8*W-1:0]      r2_c;
    logic signed [W:0]   r2_dx [4];
    logic signed [W:0]   r2_dy [4];

    // split stage
    logic                r_sv, r_ssat, r_spar;
    logic [3:0]          r_rem;
    logic signed [W-1:0] r_spx, r_spy;
    logic [8*W-1:0]      r_sc;

    // output register
    logic                r_ov, r_oseg, r_opar, r_osat, r_olast;
    logic signed [W-1:0] r_ocx, r_ocy, r_ofx, r_ofy;
    logic [1:0]          r_owhich;

    logic signed [W-1:0] ex1 [4];
    logic signed [W-1:0] ey1 [4];
    logic signed [W-1:0] ex3 [4];
    logic signed [W-1:0] ey3 [4];
    logic [3:0]          far;
    logic [CMPW-1:0]     ax, ay;
    logic [3:0]          pick;
    logic [1:0]          idx;
    logic                emit, is_last;

    always_comb begin
        n1_satx = 1'b0;
        n1_px   = $signed(i_q_x);
        if (i_ctl.ovf_x) begin
            n1_satx = 1'b1;
            n1_px   = i_ctl.neg_x ? CMIN : CMAX;
        end else if (!i_ctl.neg_x) begin
            if (i_q_x[W-1]) begin
                n1_satx = 1'b1;
                n1_px   = CMAX;
            end
        end else if (i_q_x[W-1] && (|i_q_x[W-2:0])) begin
            n1_satx = 1'b1;
            n1_px   = CMIN;
        end else begin
            n1_px = -$signed(i_q_x);
        end
        n1_saty = 1'b0;
        n1_py   = $signed(i_q_y);
        if (i_ctl.ovf_y) begin
            n1_saty = 1'b1;
            n1_py   = i_ctl.neg_y ? CMIN : CMAX;
        end else if (!i_ctl.neg_y) begin
            if (i_q_y[W-1]) begin
                n1_saty = 1'b1;
                n1_py   = CMAX;
            end
        end else if (i_q_y[W-1] && (|i_q_y[W-2:0])) begin
            n1_saty = 1'b1;
            n1_py   = CMIN;
        end else begin
            n1_py = -$signed(i_q_y);
        end
    end

    assign ex1[0] = r1_c[2*W +: W];
    assign ey1[0] = r1_c[3*W +: W];
    assign ex1[1] = r1_c[0*W +: W];
    assign ey1[1] = r1_c[1*W +: W];
    assign ex1[2] = r1_c[4*W +: W];
    assign ey1[2] = r1_c[5*W +: W];
    assign ex1[3] = r1_c[6*W +: W];
    assign ey1[3] = r1_c[7*W +: W];

    assign ex3[0] = r_sc[2*W +: W];
    assign ey3[0] = r_sc[3*W +: W];
    assign ex3[1] = r_sc[0*W +: W];
    assign ey3[1] = r_sc[1*W +: W];
    assign ex3[2] = r_sc[4*W +: W];
    assign ey3[2] = r_sc[5*W +: W];
    assign ex3[3] = r_sc[6*W +: W];
    assign ey3[3] = r_sc[7*W +: W];

    always_comb begin
        far = '0;
        ax  = '0;
        ay  = '0;
        for (int k = 0; k < 4; k++) begin
            ax = CMPW'(r2_dx[k][W] ? (W+1)'(-r2_dx[k]) : (W+1)'(r2_dx[k]));
            ay = CMPW'(r2_dy[k][W] ? (W+1)'(-r2_dy[k]) : (W+1)'(r2_dy[k]));
            far[k] = !((ax < CMPW'(i_tol)) && (ay < CMPW'(i_tol)));
        end
    end

    // lowest remaining endpoint first
    always_comb begin
        if (r_rem[0]) begin
            idx = END_FIRST_END;
        end else if (r_rem[1]) begin
            idx = END_FIRST_START;
        end else if (r_rem[2]) begin
            idx = END_SECOND_START;
        end else begin
            idx = END_SECOND_END;
        end
        pick = 4'b0001 << idx;
    end

    assign emit    = r_sv && (!r_ov || o_out.ready);
    assign is_last = r_spar || ((r_rem & ~pick) == 4'b0000);
    assign o_adv   = !r_sv || (emit && is_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r_sv <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (o_adv) begin
                r1_v <= i_ctl.valid;
                r2_v <= r1_v;
                r_sv <= r2_v;
            end
            if (emit) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv) begin
            r1_px  <= n1_px;
            r1_py  <= n1_py;
            r1_sat <= n1_satx | n1_saty;
            r1_par <= i_ctl.par;
            r1_c   <= i_coord;
            r2_px  <= r1_px;
            r2_py  <= r1_py;
            r2_sat <= r1_sat;
            r2_par <= r1_par;
            r2_c   <= r1_c;
            for (int k = 0; k < 4; k++) begin
                r2_dx[k] <= (W+1)'(r1_px) - (W+1)'(ex1[k]);
                r2_dy[k] <= (W+1)'(r1_py) - (W+1)'(ey1[k]);
            end
            r_spx  <= r2_px;
            r_spy  <= r2_py;
            r_ssat <= r2_sat;
            r_spar <= r2_par;
            r_sc   <= r2_c;
            r_rem  <= far;
        end else if (emit) begin
            r_rem <= r_rem & ~pick;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_olast <= is_last;
            if (r_spar) begin
                r_ocx    <= '0;
                r_ocy    <= '0;
                r_ofx    <= '0;
                r_ofy    <= '0;
                r_owhich <= END_FIRST_END;
                r_oseg   <= 1'b0;
                r_opar   <= 1'b1;
                r_osat   <= 1'b0;
            end else if (r_rem == 4'b0000) begin
                r_ocx    <= r_spx;
                r_ocy    <= r_spy;
                r_ofx    <= '0;
                r_ofy    <= '0;
                r_owhich <= END_FIRST_END;
                r_oseg   <= 1'b0;
                r_opar   <= 1'b0;
                r_osat   <= r_ssat;
            end else begin
                r_ocx    <= r_spx;
                r_ocy    <= r_spy;
                r_ofx    <= ex3[idx];
                r_ofy    <= ey3[idx];
                r_owhich <= idx;
                r_oseg   <= 1'b1;
                r_opar   <= 1'b0;
                r_osat   <= r_ssat;
            end
        end
    end

    assign o_out.valid         = r_ov;
    assign o_out.cross_x       = r_ocx;
    assign o_out.cross_y       = r_ocy;
    assign o_out.far_x         = r_ofx;
    assign o_out.far_y         = r_ofy;
    assign o_out.which_end     = r_owhich;
    assign o_out.segment_valid = r_oseg;
    assign o_out.parallel      = r_opar;
    assign o_out.saturated     = r_osat;
    assign o_out.last          = r_olast;

endmodule

`default_nettype wire

FILE: src/line_cross_segment_split_top.sv
// ----------------------------------------------------------------------------
// line_cross_segment_split_top
// pipeline: a front section, one divider cell per quotient bit and a back
//   section carry an accepted line word to its first result word
// throughput: one line word per cycle into the pipeline, but the result split
//   holds the pipeline while it emits up to four result words per line word
// reset: synchronous active low, clears all valid state, tolerance back to 7
// ----------------------------------------------------------------------------
`default_nettype none

module line_cross_segment_split_top #(
    parameter int COORD_WIDTH = 32
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    lcss_in_if.sink    i_in,
    lcss_out_if.source o_out,
    lcss_cfg_if.sink   i_cfg
);
    import lcss_pkg::*;

    localparam int W  = COORD_WIDTH;
    localparam int DW = 2 * W + 3;

    logic [TOL_W-1:0] r_tol;
    logic             adv;
    logic [8*W-1:0]   coord;

    t_ctl             ctl   [W+1];
    logic [8*W-1:0]   cc    [W+1];
    logic [DW-1:0]    md    [W+1];
    logic [DW-1:0]    rem_x [W+1];
    logic [DW-1:0]    rem_y [W+1];
    logic [W-1:0]     low_x [W+1];
    logic [W-1:0]     low_y [W+1];

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= TOL_RESET;
        end else if (i_cfg.valid) begin
            r_tol <= i_cfg.tolerance;
        end
    end

    assign coord = {i_in.second_end_y, i_in.second_end_x,
                    i_in.second_start_y, i_in.second_start_x,
                    i_in.first_end_y, i_in.first_end_x,
                    i_in.first_start_y, i_in.first_start_x};

    lcss_front #(.W(W)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (i_in.valid),
        .i_coord (coord),
        .o_ctl   (ctl[0]),
        .o_coord (cc[0]),
        .o_md    (md[0]),
        .o_rem_x (rem_x[0]),
        .o_rem_y (rem_y[0]),
        .o_low_x (low_x[0]),
        .o_low_y (low_y[0])
    );

    for (genvar g = 0; g < W; g++) begin : g_cell
        lcss_div_cell #(.W(W)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (adv),
            .i_ctl   (ctl[g]),
            .i_coord (cc[g]),
            .i_md    (md[g]),
            .i_rem_x (rem_x[g]),
            .i_rem_y (rem_y[g]),
            .i_low_x (low_x[g]),
            .i_low_y (low_y[g]),
            .o_ctl   (ctl[g+1]),
            .o_coord (cc[g+1]),
            .o_md    (md[g+1]),
            .o_rem_x (rem_x[g+1]),
            .o_rem_y (rem_y[g+1]),
            .o_low_x (low_x[g+1]),
            .o_low_y (low_y[g+1])
        );
    end

    lcss_back #(.W(W)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl[W]),
        .i_coord (cc[W]),
        .i_q_x   (low_x[W]),
        .i_q_y   (low_y[W]),
        .i_tol   (r_tol),
        .o_adv   (adv),
        .o_out   (o_out)
    );

endmodule

`default_nettype wire

FILE: src/lcss_chk.sv
// ----------------------------------------------------------------------------
// lcss_chk
// port checks on the result channel, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module lcss_chk #(
    parameter int W = 32
) (
    input wire         i_clk,
    input wire         i_rst_n,
    input wire         i_out_valid,
    input wire         i_out_ready,
    input wire [W-1:0] i_out_cross_x,
    input wire [W-1:0] i_out_far_x,
    input wire         i_out_segment_valid,
    input wire         i_out_parallel,
    input wire         i_out_saturated,
    input wire         i_out_last
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_cross_x)
            && $stable(i_out_far_x) && $stable(i_out_last))
        else $error("result word changed while stalled");

    a_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_segment_valid |-> i_out_last)
        else $error("word without segment is not last");

    a_par: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_parallel |-> !i_out_segment_valid && !i_out_saturated)
        else $error("parallel word carries segment or saturation");

    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

endmodule

bind line_cross_segment_split_top lcss_chk #(.W(COORD_WIDTH)) u_lcss_chk (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .i_out_valid         (o_out.valid),
    .i_out_ready         (o_out.ready),
    .i_out_cross_x       (o_out.cross_x),
    .i_out_far_x         (o_out.far_x),
    .i_out_segment_valid (o_out.segment_valid),
    .i_out_parallel      (o_out.parallel),
    .i_out_saturated     (o_out.saturated),
    .i_out_last          (o_out.last)
);

`default_nettype wire
